// ----- rtl/pdt_pkg.sv -----
// Shared types and constants for the periodic task dispatcher.
// No dependencies; imported by pdt_cfg_regs, the dispatcher and the testbench.
`timescale 1ns / 1ps

package pdt_pkg;

	localparam int NUM_PERIODIC = 3;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 16;

	// Input operation codes
	localparam logic [2:0] OP_DISPATCH   = 3'd0;
	localparam logic [2:0] OP_TOGGLE_T0  = 3'd1;
	localparam logic [2:0] OP_TOGGLE_T1  = 3'd2;
	localparam logic [2:0] OP_STEP_T0    = 3'd3;
	localparam logic [2:0] OP_SET_PERIOD = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_PERIOD  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SERIAL_LIMIT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_FLOOR = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_CEIL  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_INCR  = 3'd4;

	// Task identifiers
	localparam logic [1:0] TASK_0    = 2'd0;
	localparam logic [1:0] TASK_1    = 2'd1;
	localparam logic [1:0] TASK_2    = 2'd2;
	localparam logic [1:0] TASK_IDLE = 2'd3;

	// Reset values
	localparam logic [11:0] PERIOD0_RESET       = 12'd700;
	localparam logic [11:0] PERIOD1_RESET       = 12'd1500;
	localparam logic [11:0] PERIOD2_RESET       = 12'd2000;
	localparam logic [15:0] IDLE_PERIOD_RESET   = 16'd100;
	localparam logic [3:0]  SERIAL_LIMIT_RESET  = 4'd10;
	localparam logic [11:0] PERIOD_FLOOR_RESET  = 12'd500;
	localparam logic [11:0] PERIOD_CEIL_RESET   = 12'd3000;
	localparam logic [11:0] PERIOD_INCR_RESET   = 12'd300;

	// Digit and counter limits
	localparam logic [3:0] TENS_LAST   = 4'd9;
	localparam logic [2:0] UNITS_LAST  = 3'd5;
	localparam logic [3:0] RUNS_SAT    = 4'd15;

	typedef struct packed {
		logic [15:0] idle_period;
		logic [3:0]  serial_run_limit;
		logic [11:0] period_floor;
		logic [11:0] period_ceiling;
		logic [11:0] period_increment;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

endpackage

// ----- rtl/pdt_cfg_regs.sv -----
// Configuration register file of the periodic task dispatcher.
// Depends on pdt_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module pdt_cfg_regs
	import pdt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// Write one register per accepted word; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_period      <= IDLE_PERIOD_RESET;
			cfg_q.serial_run_limit <= SERIAL_LIMIT_RESET;
			cfg_q.period_floor     <= PERIOD_FLOOR_RESET;
			cfg_q.period_ceiling   <= PERIOD_CEIL_RESET;
			cfg_q.period_increment <= PERIOD_INCR_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_IDLE_PERIOD:  cfg_q.idle_period      <= wr_data;
				CFG_SERIAL_LIMIT: cfg_q.serial_run_limit <= wr_data[3:0];
				CFG_PERIOD_FLOOR: cfg_q.period_floor     <= wr_data[11:0];
				CFG_PERIOD_CEIL:  cfg_q.period_ceiling   <= wr_data[11:0];
				CFG_PERIOD_INCR:  cfg_q.period_increment <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/pdt_elapsed_cmp.sv -----
// Shared elapsed-time unit: wrapped subtract of a start tick from now,
// compared against a period. No package dependencies.
`timescale 1ns / 1ps

module pdt_elapsed_cmp #(
	parameter int TICK_WIDTH = 32
) (
	input  logic [TICK_WIDTH-1:0] now,
	input  logic [TICK_WIDTH-1:0] start,
	input  logic [15:0]           period,
	output logic                  due
);

	logic [TICK_WIDTH-1:0] elapsed;

	// Subtract modulo 2^TICK_WIDTH, then compare with the period
	assign elapsed = now - start;
	assign due     = (elapsed >= TICK_WIDTH'(period));

endmodule

// ----- rtl/periodic_task_dispatcher.sv -----
// Periodic task dispatcher: three fixed-priority periodic tasks and one idle
// task. Every input word yields exactly one result word. A dispatch word is
// handled by a sequencer that checks tasks 0, 1, 2 and then the idle task, one
// per cycle, through a single shared elapsed-time comparator: a dispatch is
// accepted, checks tasks in order until the first due one, then loads the
// output register. Toggle, step and set-period words pass through the execute
// state, then load the output register. in_stall is high while a word is in
// progress; the output register lets the next word be accepted while a result
// still waits to be taken. Configuration writes are always ready. Depends on
// pdt_pkg, pdt_cfg_regs and pdt_elapsed_cmp.
`timescale 1ns / 1ps

module periodic_task_dispatcher
	import pdt_pkg::*;
#(
	parameter int TICK_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [2:0]             op,
	input  logic [31:0]            now_tick,
	input  logic [1:0]             target_task,
	input  logic [15:0]            requested_period,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   dispatched,
	output logic [1:0]             task_id,
	output logic                   both_off,
	output logic [3:0]             tens_digit,
	output logic [2:0]             units_digit,
	// configuration channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t cfg;

	state_t state_q;

	logic [2:0]            op_q;
	logic [TICK_WIDTH-1:0] now_q;
	logic [1:0]            target_q;
	logic [15:0]           req_q;
	logic [1:0]            scan_idx_q;

	logic [TICK_WIDTH-1:0] last_start_q [0:3];
	logic [11:0]           period_q     [0:NUM_PERIODIC-1];
	logic [NUM_PERIODIC-1:0] paused_q;
	logic [3:0]            serial_runs_q;
	logic                  both_paused_q;
	logic [3:0]            tens_q;
	logic [2:0]            units_q;

	logic                  ran_q;
	logic [1:0]            ran_id_q;

	logic                  out_valid_q;
	logic                  dispatched_q;
	logic [1:0]            task_id_q;
	logic                  both_off_q;
	logic [3:0]            tens_out_q;
	logic [2:0]            units_out_q;

	logic                  in_accept;
	logic                  out_take;
	logic                  out_load;
	logic [15:0]           cmp_period;
	logic                  cmp_due;
	logic                  task_active;
	logic                  hit;
	logic [3:0]            runs_next;
	logic [12:0]           step_sum;

	// Configuration registers
	assign cfg_ready = 1'b1;

	pdt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Pick the period and pause flag of the task under test
	always_comb begin
		case (scan_idx_q)
			TASK_0: begin
				cmp_period  = {4'd0, period_q[0]};
				task_active = !paused_q[0];
			end
			TASK_1: begin
				cmp_period  = {4'd0, period_q[1]};
				task_active = !paused_q[1];
			end
			TASK_2: begin
				cmp_period  = {4'd0, period_q[2]};
				task_active = !paused_q[2];
			end
			default: begin
				cmp_period  = cfg.idle_period;
				task_active = 1'b1;
			end
		endcase
	end

	pdt_elapsed_cmp #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_cmp (
		.now    (now_q),
		.start  (last_start_q[scan_idx_q]),
		.period (cmp_period),
		.due    (cmp_due)
	);

	assign hit       = cmp_due && task_active;
	assign runs_next = (serial_runs_q < RUNS_SAT) ? serial_runs_q + 4'd1 : serial_runs_q;
	assign step_sum  = {1'b0, period_q[0]} + {1'b0, cfg.period_increment};

	// Handshakes
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// Sequencer and task state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			scan_idx_q    <= TASK_0;
			for (int i = 0; i < 4; i++)
				last_start_q[i] <= '0;
			period_q[0]   <= PERIOD0_RESET;
			period_q[1]   <= PERIOD1_RESET;
			period_q[2]   <= PERIOD2_RESET;
			paused_q      <= '0;
			serial_runs_q <= '0;
			both_paused_q <= 1'b0;
			tens_q        <= '0;
			units_q       <= '0;
			ran_q         <= 1'b0;
			ran_id_q      <= TASK_0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						ran_q      <= 1'b0;
						ran_id_q   <= TASK_0;
						scan_idx_q <= TASK_0;
						state_q    <= (op == OP_DISPATCH) ? ST_SCAN : ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (op_q)
						OP_TOGGLE_T0: begin
							paused_q[0]   <= !paused_q[0];
							both_paused_q <= !paused_q[0] && paused_q[1];
						end
						OP_TOGGLE_T1: begin
							paused_q[1]   <= !paused_q[1];
							both_paused_q <= paused_q[0] && !paused_q[1];
						end
						OP_STEP_T0: begin
							if (step_sum > {1'b0, cfg.period_ceiling})
								period_q[0] <= cfg.period_floor;
							else
								period_q[0] <= step_sum[11:0];
						end
						OP_SET_PERIOD: begin
							if (target_q != TASK_IDLE
									&& req_q >= {4'd0, cfg.period_floor}
									&& req_q <= {4'd0, cfg.period_ceiling})
								period_q[target_q] <= req_q[11:0];
						end
						default: ;
					endcase
					state_q <= ST_FIN;
				end
				ST_SCAN: begin
					// Run the first due task, else advance to the next one
					if (hit) begin
						last_start_q[scan_idx_q] <= now_q;
						ran_q    <= 1'b1;
						ran_id_q <= scan_idx_q;
						if (scan_idx_q == TASK_2) begin
							serial_runs_q <= runs_next;
							if (runs_next >= cfg.serial_run_limit)
								paused_q[2] <= 1'b1;
						end
						if (scan_idx_q == TASK_IDLE && !both_paused_q) begin
							tens_q  <= (tens_q == TENS_LAST) ? 4'd0 : tens_q + 4'd1;
							units_q <= (units_q == UNITS_LAST) ? 3'd0 : units_q + 3'd1;
						end
						state_q <= ST_FIN;
					end else if (scan_idx_q == TASK_IDLE) begin
						state_q <= ST_FIN;
					end else begin
						scan_idx_q <= scan_idx_q + 2'd1;
					end
				end
				ST_FIN: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the accepted word
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q     <= op;
			now_q    <= TICK_WIDTH'(now_tick);
			target_q <= target_task;
			req_q    <= requested_period;
		end
	end

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dispatched_q <= ran_q;
			task_id_q    <= ran_id_q;
			both_off_q   <= both_paused_q;
			tens_out_q   <= tens_q;
			units_out_q  <= units_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign dispatched  = dispatched_q;
	assign task_id     = task_id_q;
	assign both_off    = both_off_q;
	assign tens_digit  = tens_out_q;
	assign units_digit = units_out_q;

	// Assertions
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_idx_q == TASK_IDLE) |=> (state_q != ST_SCAN))
		else $error("scan did not finish after the idle task");

	a_serial_stays_paused: assert property (@(posedge clk) disable iff (!arst_n)
		paused_q[2] |=> paused_q[2])
		else $error("task 2 left its permanent pause");

	a_both_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		both_paused_q == (paused_q[0] && paused_q[1]))
		else $error("both-paused flag out of step with pause flags");

	a_digits_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tens_q <= TENS_LAST) && (units_q <= UNITS_LAST))
		else $error("idle digit out of range");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == ST_SCAN || state_q == ST_EXEC))
		else $error("accepted word did not start work");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for periodic_task_dispatcher: directed and random traffic,
// register sweeps and a long output hold-off, checked against an in-line predictor.
// Depends on pdt_pkg and the dispatcher RTL.
`timescale 1ns / 1ps

module testbench
	import pdt_pkg::*;
;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 2;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 16;

	// Opcodes the block must treat as no-ops
	localparam logic [2:0] OP_RESERVED_LO = 3'd5;
	localparam logic [2:0] OP_RESERVED_HI = 3'd7;

	typedef struct packed {
		logic       dispatched;
		logic [1:0] task_id;
		logic       both_off;
		logic [3:0] tens;
		logic [2:0] units;
	} status_t;

	logic                   clk              = 1'b0;
	logic                   arst_n           = 1'b0;
	logic                   in_valid         = 1'b0;
	logic                   in_stall;
	logic [2:0]             op               = OP_DISPATCH;
	logic [31:0]            now_tick         = '0;
	logic [1:0]             target_task      = TASK_0;
	logic [15:0]            requested_period = '0;
	logic                   out_valid;
	logic                   out_stall        = 1'b0;
	logic                   dispatched;
	logic [1:0]             task_id;
	logic                   both_off;
	logic [3:0]             tens_digit;
	logic [2:0]             units_digit;
	logic                   cfg_valid        = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index        = CFG_IDLE_PERIOD;
	logic [CFG_DATA_W-1:0]  cfg_data         = '0;

	// Predicted block state
	logic [31:0] start_model [4];
	logic [11:0] period_model [NUM_PERIODIC];
	logic        paused_model [NUM_PERIODIC];
	logic [3:0]  serial_count;
	logic        both_model;
	logic [3:0]  tens_model;
	logic [2:0]  units_model;
	cfg_t        cfg_model;

	status_t     expected_status_q [$];
	status_t     oldest_status;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned tx_idle_pct    = 28;
	int unsigned rx_idle_pct    = 77;
	int unsigned hold_left      = 0;
	bit          hold_request   = 1'b0;
	logic [31:0] tick_now       = '0;

	periodic_task_dispatcher u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (op),
		.now_tick         (now_tick),
		.target_task      (target_task),
		.requested_period (requested_period),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.dispatched       (dispatched),
		.task_id          (task_id),
		.both_off         (both_off),
		.tens_digit       (tens_digit),
		.units_digit      (units_digit),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// Advance the predicted state by one word and return its status
	function automatic status_t compute_status(input logic [2:0] w_op, input logic [31:0] tick,
			input logic [1:0] tgt, input logic [15:0] req);
		status_t     s;
		logic [31:0] elapsed;
		logic [12:0] sum;
		int          ran;
		ran = -1;
		case (w_op)
			OP_DISPATCH: begin
				// scan periodic tasks in priority order, first due one wins
				for (int i = 0; i < NUM_PERIODIC; i++) begin
					if (ran < 0) begin
						elapsed = tick - start_model[i];
						if (!paused_model[i] && elapsed >= {20'd0, period_model[i]}) begin
							ran = i;
							start_model[i] = tick;
							if (i == TASK_2) begin
								if (serial_count < RUNS_SAT)
									serial_count++;
								if (serial_count >= cfg_model.serial_run_limit)
									paused_model[TASK_2] = 1'b1;
							end
						end
					end
				end
				// fall back to the idle task
				if (ran < 0) begin
					elapsed = tick - start_model[TASK_IDLE];
					if (elapsed >= {16'd0, cfg_model.idle_period}) begin
						ran = TASK_IDLE;
						start_model[TASK_IDLE] = tick;
						if (!both_model) begin
							tens_model  = (tens_model == TENS_LAST) ? 4'd0 : tens_model + 4'd1;
							units_model = (units_model == UNITS_LAST) ? 3'd0 : units_model + 3'd1;
						end
					end
				end
			end
			OP_TOGGLE_T0: begin
				paused_model[TASK_0] = !paused_model[TASK_0];
				both_model = paused_model[TASK_0] && paused_model[TASK_1];
			end
			OP_TOGGLE_T1: begin
				paused_model[TASK_1] = !paused_model[TASK_1];
				both_model = paused_model[TASK_0] && paused_model[TASK_1];
			end
			OP_STEP_T0: begin
				// wide sum, wrap to floor when past ceiling
				sum = {1'b0, period_model[TASK_0]} + {1'b0, cfg_model.period_increment};
				if (sum > {1'b0, cfg_model.period_ceiling})
					period_model[TASK_0] = cfg_model.period_floor;
				else
					period_model[TASK_0] = sum[11:0];
			end
			OP_SET_PERIOD: begin
				if (tgt != TASK_IDLE && req >= {4'd0, cfg_model.period_floor}
						&& req <= {4'd0, cfg_model.period_ceiling})
					period_model[tgt] = req[11:0];
			end
			default: ;
		endcase
		s.dispatched = (ran >= 0);
		s.task_id    = (ran >= 0) ? 2'(ran) : TASK_0;
		s.both_off   = both_model;
		s.tens       = tens_model;
		s.units      = units_model;
		return s;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			mismatch_count++;
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
		end
	endtask

	// Compare each taken result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_status_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with none expected, actual %0d %0d %0d %0d %0d", $time,
					dispatched, task_id, both_off, tens_digit, units_digit);
			end else begin
				oldest_status = expected_status_q.pop_front();
				check_field("dispatched", 32'(oldest_status.dispatched), 32'(dispatched));
				check_field("task_id", 32'(oldest_status.task_id), 32'(task_id));
				check_field("both_off", 32'(oldest_status.both_off), 32'(both_off));
				check_field("tens_digit", 32'(oldest_status.tens), 32'(tens_digit));
				check_field("units_digit", 32'(oldest_status.units), 32'(units_digit));
			end
		end
	end

	// Drive output stall: random, or held off for a long stretch on request
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLDOFF_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// Offer one input word, hold it until taken, then record its prediction
	task automatic send_word(input logic [2:0] w_op, input logic [31:0] tick,
			input logic [1:0] tgt, input logic [15:0] req);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		op               <= w_op;
		now_tick         <= tick;
		target_task      <= tgt;
		requested_period <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_status_q.push_back(compute_status(w_op, tick, tgt, req));
	endtask

	// Drop input valid and wait until every result has been taken
	task automatic drain_to_idle();
		in_valid <= 1'b0;
		while (expected_status_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_IDLE_PERIOD:  cfg_model.idle_period      = val;
			CFG_SERIAL_LIMIT: cfg_model.serial_run_limit = val[3:0];
			CFG_PERIOD_FLOOR: cfg_model.period_floor     = val[11:0];
			CFG_PERIOD_CEIL:  cfg_model.period_ceiling   = val[11:0];
			CFG_PERIOD_INCR:  cfg_model.period_increment = val[11:0];
			default: ;
		endcase
	endtask

	// Write all registers while the block is idle
	task automatic program_config(input cfg_t c);
		drain_to_idle();
		write_reg(CFG_IDLE_PERIOD, c.idle_period);
		write_reg(CFG_SERIAL_LIMIT, {12'd0, c.serial_run_limit});
		write_reg(CFG_PERIOD_FLOOR, {4'd0, c.period_floor});
		write_reg(CFG_PERIOD_CEIL, {4'd0, c.period_ceiling});
		write_reg(CFG_PERIOD_INCR, {4'd0, c.period_increment});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly dispatches on a rising tick, mixed with control words and noise
	task automatic random_items(input int count);
		logic [2:0]  w_op;
		logic [31:0] tick;
		logic [1:0]  tgt;
		logic [15:0] req;
		int unsigned sel;
		int unsigned pick;
		for (int n = 0; n < count; n++) begin
			sel  = $urandom_range(0, 99);
			tgt  = 2'($urandom_range(0, 3));
			tick = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 60)
				req = 16'($urandom_range(cfg_model.period_floor, cfg_model.period_ceiling));
			else if (pick < 80)
				req = $urandom_range(0, 1) ? {4'd0, cfg_model.period_floor} - 16'd1
					: {4'd0, cfg_model.period_ceiling} + 16'd1;
			else
				req = 16'($urandom_range(0, 65535));
			if (sel < 70) begin
				w_op = OP_DISPATCH;
				pick = $urandom_range(0, 99);
				if (pick < 80)
					tick_now = tick_now + $urandom_range(0, 300);
				else if (pick < 95)
					tick_now = tick_now + $urandom_range(0, 4500);
				else
					tick_now = $urandom;
				tick = tick_now;
			end else if (sel < 76) begin
				w_op = OP_TOGGLE_T0;
			end else if (sel < 82) begin
				w_op = OP_TOGGLE_T1;
			end else if (sel < 88) begin
				w_op = OP_STEP_T0;
			end else if (sel < 97) begin
				w_op = OP_SET_PERIOD;
			end else begin
				w_op = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
			end
			send_word(w_op, tick, tgt, req);
		end
	endtask

	// Reset values, tick wrap, pause of both tasks, step wrap, set-period bounds
	task automatic test_directed();
		send_word(OP_DISPATCH, 32'd0, TASK_0, 16'd0);
		send_word(OP_DISPATCH, 32'd100, TASK_0, 16'd0);
		send_word(OP_DISPATCH, 32'd700, TASK_0, 16'd0);
		send_word(OP_DISPATCH, 32'd1500, TASK_0, 16'd0);
		send_word(OP_DISPATCH, 32'd2000, TASK_0, 16'd0);
		send_word(OP_DISPATCH, 32'hFFFF_FFFF, TASK_0, 16'd0);
		send_word(OP_DISPATCH, 32'h0000_0010, TASK_0, 16'd0);
		// both periodic tasks paused: idle runs must hold the digits
		send_word(OP_TOGGLE_T0, 32'd0, TASK_0, 16'd0);
		send_word(OP_TOGGLE_T1, 32'd0, TASK_0, 16'd0);
		send_word(OP_DISPATCH, 32'h8000_0000, TASK_0, 16'd0);
		send_word(OP_DISPATCH, 32'h8000_1000, TASK_0, 16'd0);
		send_word(OP_TOGGLE_T0, 32'd0, TASK_0, 16'd0);
		send_word(OP_TOGGLE_T1, 32'd0, TASK_0, 16'd0);
		// step task 0 until it wraps back to the floor
		for (int n = 0; n < 8; n++)
			send_word(OP_STEP_T0, 32'd0, TASK_0, 16'd0);
		send_word(OP_SET_PERIOD, 32'd0, TASK_0, {4'd0, cfg_model.period_floor} - 16'd1);
		send_word(OP_SET_PERIOD, 32'd0, TASK_1, {4'd0, cfg_model.period_floor});
		send_word(OP_SET_PERIOD, 32'd0, TASK_2, {4'd0, cfg_model.period_ceiling});
		send_word(OP_SET_PERIOD, 32'd0, TASK_0, {4'd0, cfg_model.period_ceiling} + 16'd1);
		send_word(OP_SET_PERIOD, 32'd0, TASK_IDLE, 16'd1000);
		send_word(OP_SET_PERIOD, 32'd0, TASK_1, 16'hFFFF);
		send_word(OP_RESERVED_LO, 32'hFFFF_FFFF, TASK_IDLE, 16'hFFFF);
		send_word(OP_RESERVED_HI, 32'd0, TASK_0, 16'd0);
	endtask

	task automatic test_random_defaults();
		tx_idle_pct = 28;
		rx_idle_pct = 77;
		random_items(700);
	endtask

	task automatic test_random_low_extremes();
		cfg_t c;
		c.idle_period      = 16'd1;
		c.serial_run_limit = 4'd15;
		c.period_floor     = 12'd1;
		c.period_ceiling   = 12'd4095;
		c.period_increment = 12'd4095;
		program_config(c);
		tx_idle_pct = 77;
		rx_idle_pct = 28;
		tick_now = 32'hFFFF_F000;
		random_items(700);
	endtask

	// Hold the output off while words keep coming so the block fills up
	task automatic test_backpressure();
		cfg_t c;
		c.idle_period      = 16'd250;
		c.serial_run_limit = 4'd12;
		c.period_floor     = 12'd200;
		c.period_ceiling   = 12'd2500;
		c.period_increment = 12'd700;
		program_config(c);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_request = 1'b1;
		random_items(40);
	endtask

	task automatic test_random_high_extremes();
		cfg_t c;
		c.idle_period      = 16'd65535;
		c.serial_run_limit = 4'd1;
		c.period_floor     = 12'd4095;
		c.period_ceiling   = 12'd4095;
		c.period_increment = 12'd0;
		program_config(c);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_items(600);
	endtask

	initial begin
		// predicted state after reset
		for (int i = 0; i < 4; i++)
			start_model[i] = '0;
		for (int i = 0; i < NUM_PERIODIC; i++)
			paused_model[i] = 1'b0;
		period_model[TASK_0] = PERIOD0_RESET;
		period_model[TASK_1] = PERIOD1_RESET;
		period_model[TASK_2] = PERIOD2_RESET;
		serial_count = '0;
		both_model   = 1'b0;
		tens_model   = '0;
		units_model  = '0;
		cfg_model.idle_period      = IDLE_PERIOD_RESET;
		cfg_model.serial_run_limit = SERIAL_LIMIT_RESET;
		cfg_model.period_floor     = PERIOD_FLOOR_RESET;
		cfg_model.period_ceiling   = PERIOD_CEIL_RESET;
		cfg_model.period_increment = PERIOD_INCR_RESET;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_defaults();
		test_random_low_extremes();
		test_backpressure();
		test_random_high_extremes();
		drain_to_idle();

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/pdt_pkg.sv
rtl/pdt_cfg_regs.sv
rtl/pdt_elapsed_cmp.sv
rtl/periodic_task_dispatcher.sv
sim/testbench.sv
